[rtl/sauv_pkg.sv]
// ----------------------------------------------------------------------------
// sauv_pkg: shared types and constants for the unique-value sorter
// Result beat layout, controller state codes and default store capacity.
// ----------------------------------------------------------------------------
package sauv_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // one result beat
    typedef struct packed {
        value_t unique_value;
        logic   end_of_run;
        logic   none_found;
        logic   overflowed;
    } result_t;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SHIFT     = 6'b000010,
        ST_PLACE     = 6'b000100,
        ST_SCAN_RD   = 6'b001000,
        ST_SCAN_EVAL = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

endpackage

[rtl/sauv_store.sv]
// ----------------------------------------------------------------------------
// sauv_store: sorted element store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sauv_store #(
    parameter int DEPTH = sauv_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  sauv_pkg::value_t  wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output sauv_pkg::value_t  rd_data
);

    sauv_pkg::value_t mem [DEPTH];
    sauv_pkg::value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data when no read is issued
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sauv_seq.sv]
// ----------------------------------------------------------------------------
// sauv_seq: insertion and scan sequencer
// Inserts each element by shifting larger entries up one slot per cycle,
// then walks the store once and pushes every value seen exactly once.
// ----------------------------------------------------------------------------
module sauv_seq #(
    parameter int CAPACITY = sauv_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    // input beat
    input  logic              item_valid,
    output logic              item_ready,
    input  sauv_pkg::value_t  value,
    input  logic              is_last,
    // result push into the output register
    input  logic              slot_free,
    output logic              push,
    output sauv_pkg::result_t push_data,
    // store ports
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output sauv_pkg::value_t  wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  sauv_pkg::value_t  rd_data
);

    sauv_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             last_reg, last_next;
    sauv_pkg::value_t val_reg, val_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [CW-1:0]    idx_reg, idx_next;
    sauv_pkg::value_t prev_reg, prev_next;
    logic             have_prev_reg, have_prev_next;
    sauv_pkg::value_t cur_reg, cur_next;
    logic             have_cur_reg, have_cur_next;
    sauv_pkg::value_t pend_reg, pend_next;
    logic             pend_vld_reg, pend_vld_next;

    logic [CW-1:0]    cnt_m1;
    logic [AW-1:0]    jm1;
    logic [AW-1:0]    jm2;
    logic             accept;
    logic             full;
    logic             left_diff;
    logic             uniq_mid;
    logic             uniq_end;

    assign cnt_m1    = count_reg - CW'(1);
    assign jm1       = j_reg - AW'(1);
    assign jm2       = jm1 - AW'(1);
    assign item_ready = (state_reg == sauv_pkg::ST_IDLE);
    assign accept    = item_valid && item_ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign left_diff = !have_prev_reg || (prev_reg != cur_reg);
    assign uniq_mid  = have_cur_reg && left_diff && (cur_reg != rd_data);
    assign uniq_end  = have_cur_reg && left_diff;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        val_next       = val_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        cur_next       = cur_reg;
        have_cur_next  = have_cur_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        wr_en          = 1'b0;
        wr_addr        = j_reg;
        wr_data        = val_reg;
        rd_en          = 1'b0;
        rd_addr        = jm1;
        push           = 1'b0;
        push_data      = '{unique_value: pend_reg, end_of_run: 1'b0,
                           none_found: 1'b0, overflowed: ovf_reg};

        unique case (state_reg)
            sauv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    val_next       = value;
                    last_next      = is_last;
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    have_cur_next  = 1'b0;
                    pend_vld_next  = 1'b0;
                    if (full)
                    begin
                        // drop the element, judge the set on what is stored
                        ovf_next = 1'b1;
                        if (is_last)
                        begin
                            state_next = sauv_pkg::ST_SCAN_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = value;
                        count_next = CW'(1);
                        if (is_last)
                        begin
                            state_next = sauv_pkg::ST_SCAN_RD;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cnt_m1[AW-1:0];
                        j_next     = count_reg[AW-1:0];
                        state_next = sauv_pkg::ST_SHIFT;
                    end
                end
            end

            sauv_pkg::ST_SHIFT:
            begin
                // rd_data holds entry j-1
                wr_en = 1'b1;
                if (val_reg < rd_data)
                begin
                    wr_data = rd_data;
                    j_next  = jm1;
                    if (jm1 == '0)
                    begin
                        state_next = sauv_pkg::ST_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = jm2;
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? sauv_pkg::ST_SCAN_RD : sauv_pkg::ST_IDLE;
                end
            end

            sauv_pkg::ST_PLACE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? sauv_pkg::ST_SCAN_RD : sauv_pkg::ST_IDLE;
            end

            sauv_pkg::ST_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = sauv_pkg::ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    idx_next   = idx_reg + CW'(1);
                    state_next = sauv_pkg::ST_SCAN_EVAL;
                end
            end

            sauv_pkg::ST_SCAN_EVAL:
            begin
                // hold here while an older candidate cannot leave
                if (!(uniq_mid && pend_vld_reg && !slot_free))
                begin
                    push = uniq_mid && pend_vld_reg;
                    if (uniq_mid)
                    begin
                        pend_next     = cur_reg;
                        pend_vld_next = 1'b1;
                    end
                    if (have_cur_reg)
                    begin
                        prev_next      = cur_reg;
                        have_prev_next = 1'b1;
                    end
                    cur_next      = rd_data;
                    have_cur_next = 1'b1;
                    state_next    = sauv_pkg::ST_SCAN_RD;
                end
            end

            sauv_pkg::ST_FINISH:
            begin
                if (uniq_end)
                begin
                    // last stored element is unique: retire the older candidate first
                    if (!pend_vld_reg || slot_free)
                    begin
                        push          = pend_vld_reg;
                        pend_next     = cur_reg;
                        pend_vld_next = 1'b1;
                        have_cur_next = 1'b0;
                    end
                end
                else if (slot_free)
                begin
                    push = 1'b1;
                    push_data.end_of_run = 1'b1;
                    if (!pend_vld_reg)
                    begin
                        push_data.unique_value = '0;
                        push_data.none_found   = 1'b1;
                    end
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = sauv_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sauv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sauv_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            have_cur_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            have_prev_reg <= have_prev_next;
            have_cur_reg  <= have_cur_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        j_reg    <= j_next;
        idx_reg  <= idx_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

endmodule

[rtl/sort_and_report_unique_values.sv]
// ----------------------------------------------------------------------------
// sort_and_report_unique_values: report the values that occur once in a set
// Usage:
//   Input channel (item_valid/item_ready) carries one element per beat:
//   value and is_last.  The beat with is_last set is an element too and
//   closes the set.  Elements beyond CAPACITY are dropped and every result
//   of that set carries overflowed.
//   Output channel (result_valid/result_ready) delivers, in ascending
//   order, each value that occurs exactly once; end_of_run marks the last
//   beat of the set.  If no value is unique, one beat with none_found and
//   end_of_run set and unique_value zero is sent.
//   Throughput: an element taken into an empty store is written at once.
//   One that lands in slot p of a store holding n entries holds item_ready
//   low while the n - p larger entries shift up (shift loop, one store
//   entry per cycle on the single write port).  The closing scan visits
//   each store entry in a read state and an evaluate state, then ends in
//   the finish state.
//   Stall: a held result stops the scan; the next set is taken once the
//   final beat of the current set sits in the output register.
//   Reset: clears the element count, overflow flag and output valid flag;
//   store contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module sort_and_report_unique_values #(
    parameter int CAPACITY = sauv_pkg::CAPACITY_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic signed [31:0]      value,
    input  logic                    is_last,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic signed [31:0]      unique_value,
    output logic                    end_of_run,
    output logic                    none_found,
    output logic                    overflowed
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    sauv_pkg::value_t  wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    sauv_pkg::value_t  rd_data;
    logic              push;
    sauv_pkg::result_t push_data;
    logic              slot_free;

    // output register
    logic              out_vld_reg;
    sauv_pkg::result_t out_reg;

    sauv_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sauv_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .is_last    (is_last),
        .slot_free  (slot_free),
        .push       (push),
        .push_data  (push_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // slot opens when empty or when the current beat leaves this cycle
    assign slot_free = !out_vld_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (push)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // load payload only on a push; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_reg <= push_data;
        end
    end

    assign result_valid = out_vld_reg;
    assign unique_value = out_reg.unique_value;
    assign end_of_run   = out_reg.end_of_run;
    assign none_found   = out_reg.none_found;
    assign overflowed   = out_reg.overflowed;

endmodule
